// ----- hdl/eci_pkg.sv -----
package eci_pkg;

  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS);
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned RA_W       = 5;
  localparam int unsigned NUM_UOPS   = 49;
  localparam int unsigned PC_W       = $clog2(NUM_UOPS);

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;

  localparam logic [63:0] Q_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    OP_XSUB,
    OP_SSUB,
    OP_SADD,
    OP_MUL,
    OP_DIV
  } op_e;

  // scratch register file addresses
  localparam logic [RA_W-1:0] R_X0  = 5'd0;
  localparam logic [RA_W-1:0] R_X1  = 5'd1;
  localparam logic [RA_W-1:0] R_X2  = 5'd2;
  localparam logic [RA_W-1:0] R_X3  = 5'd3;
  localparam logic [RA_W-1:0] R_F0  = 5'd4;
  localparam logic [RA_W-1:0] R_F1  = 5'd5;
  localparam logic [RA_W-1:0] R_F2  = 5'd6;
  localparam logic [RA_W-1:0] R_F3  = 5'd7;
  localparam logic [RA_W-1:0] R_A1  = 5'd8;
  localparam logic [RA_W-1:0] R_A2  = 5'd9;
  localparam logic [RA_W-1:0] R_A3  = 5'd10;
  localparam logic [RA_W-1:0] R_T   = 5'd11;
  localparam logic [RA_W-1:0] R_U   = 5'd12;
  localparam logic [RA_W-1:0] R_V   = 5'd13;
  localparam logic [RA_W-1:0] R_C0  = 5'd14;
  localparam logic [RA_W-1:0] R_C1  = 5'd15;
  localparam logic [RA_W-1:0] R_C2  = 5'd16;
  localparam logic [RA_W-1:0] R_D10 = 5'd17;
  localparam logic [RA_W-1:0] R_D20 = 5'd18;
  localparam logic [RA_W-1:0] R_D21 = 5'd19;
  localparam logic [RA_W-1:0] R_D30 = 5'd20;
  localparam logic [RA_W-1:0] R_D31 = 5'd21;
  localparam logic [RA_W-1:0] R_D32 = 5'd22;

  typedef struct packed {
    op_e             op;
    logic [RA_W-1:0] dst;
    logic [RA_W-1:0] sa;
    logic [RA_W-1:0] sb;
  } uop_t;

  typedef struct packed {
    logic       accept;
    logic       load_en;
    logic [2:0] load_idx;
    logic       rd_en;
    uop_t       uop;
    logic       mul_start;
    logic       div_start;
    logic       wb_en;
    logic       commit;
    logic       emit_en;
    logic [1:0] emit_idx;
  } cmd_t;

  typedef struct packed {
    logic k_ge3;
    logic last;
    logic short_curve;
    logic win_err;
    logic mul_done;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic logic [63:0] mag64(input logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic [63:0] apply_sign(input logic neg, input logic [63:0] m,
                                             input logic ovf);
    logic [63:0] r;
    if (neg) begin
      r = (ovf || m[63]) ? Q_MIN : (64'd0 - m);
    end else begin
      r = (ovf || m[63]) ? Q_MAX : m;
    end
    return r;
  endfunction

  function automatic uop_t mk(input op_e o, input logic [RA_W-1:0] d,
                              input logic [RA_W-1:0] a, input logic [RA_W-1:0] b);
    uop_t u;
    u.op  = o;
    u.dst = d;
    u.sa  = a;
    u.sb  = b;
    return u;
  endfunction

  // fit program: divided differences, then monomial conversion
  function automatic uop_t uprog(input logic [PC_W-1:0] pc);
    uop_t u;
    case (int'(pc))
      0:  u = mk(OP_XSUB, R_D10, R_X1, R_X0);
      1:  u = mk(OP_XSUB, R_D20, R_X2, R_X0);
      2:  u = mk(OP_XSUB, R_D21, R_X2, R_X1);
      3:  u = mk(OP_XSUB, R_D30, R_X3, R_X0);
      4:  u = mk(OP_XSUB, R_D31, R_X3, R_X1);
      5:  u = mk(OP_XSUB, R_D32, R_X3, R_X2);
      6:  u = mk(OP_SSUB, R_T,   R_F1, R_F0);
      7:  u = mk(OP_DIV,  R_A1,  R_T,  R_D10);
      8:  u = mk(OP_SSUB, R_T,   R_F2, R_F0);
      9:  u = mk(OP_MUL,  R_U,   R_A1, R_D20);
      10: u = mk(OP_SSUB, R_T,   R_T,  R_U);
      11: u = mk(OP_MUL,  R_U,   R_D21, R_D20);
      12: u = mk(OP_DIV,  R_A2,  R_T,  R_U);
      13: u = mk(OP_SSUB, R_T,   R_F3, R_F0);
      14: u = mk(OP_MUL,  R_U,   R_A1, R_D30);
      15: u = mk(OP_SSUB, R_T,   R_T,  R_U);
      16: u = mk(OP_MUL,  R_U,   R_A2, R_D31);
      17: u = mk(OP_MUL,  R_U,   R_U,  R_D30);
      18: u = mk(OP_SSUB, R_T,   R_T,  R_U);
      19: u = mk(OP_MUL,  R_U,   R_D32, R_D31);
      20: u = mk(OP_MUL,  R_U,   R_U,  R_D30);
      21: u = mk(OP_DIV,  R_A3,  R_T,  R_U);
      22: u = mk(OP_MUL,  R_U,   R_A1, R_X0);
      23: u = mk(OP_SSUB, R_T,   R_F0, R_U);
      24: u = mk(OP_MUL,  R_U,   R_A2, R_X1);
      25: u = mk(OP_MUL,  R_U,   R_U,  R_X0);
      26: u = mk(OP_SADD, R_T,   R_T,  R_U);
      27: u = mk(OP_MUL,  R_U,   R_A3, R_X2);
      28: u = mk(OP_MUL,  R_U,   R_U,  R_X1);
      29: u = mk(OP_MUL,  R_U,   R_U,  R_X0);
      30: u = mk(OP_SSUB, R_C0,  R_T,  R_U);
      31: u = mk(OP_MUL,  R_U,   R_A2, R_X0);
      32: u = mk(OP_SSUB, R_T,   R_A1, R_U);
      33: u = mk(OP_MUL,  R_U,   R_A2, R_X1);
      34: u = mk(OP_SSUB, R_T,   R_T,  R_U);
      35: u = mk(OP_MUL,  R_U,   R_A3, R_X1);
      36: u = mk(OP_MUL,  R_U,   R_U,  R_X0);
      37: u = mk(OP_SADD, R_T,   R_T,  R_U);
      38: u = mk(OP_MUL,  R_V,   R_A3, R_X2);
      39: u = mk(OP_MUL,  R_U,   R_V,  R_X0);
      40: u = mk(OP_SADD, R_T,   R_T,  R_U);
      41: u = mk(OP_MUL,  R_U,   R_V,  R_X1);
      42: u = mk(OP_SADD, R_C1,  R_T,  R_U);
      43: u = mk(OP_MUL,  R_U,   R_A3, R_X0);
      44: u = mk(OP_SSUB, R_T,   R_A2, R_U);
      45: u = mk(OP_MUL,  R_U,   R_A3, R_X1);
      46: u = mk(OP_SSUB, R_T,   R_T,  R_U);
      47: u = mk(OP_MUL,  R_U,   R_A3, R_X2);
      48: u = mk(OP_SSUB, R_C2,  R_T,  R_U);
      default: u = mk(OP_XSUB, R_T, R_X0, R_X0);
    endcase
    return u;
  endfunction

endpackage

// ----- hdl/eci_mul.sv -----
module eci_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic         busy_q, fin_q, done_q, neg_q;
  logic [1:0]   step_q;
  logic [63:0]  am_q, bm_q, res_q;
  logic [127:0] acc_q;
  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  // one 32x32 partial product per cycle
  assign ah = step_q[1] ? am_q[63:32] : am_q[31:0];
  assign bh = step_q[0] ? bm_q[63:32] : bm_q[31:0];
  assign pp = ah * bh;

  always_comb begin
    case (step_q)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        fin_q  <= 1'b0;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      am_q  <= eci_pkg::mag64(a_i);
      bm_q  <= eci_pkg::mag64(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end else if (fin_q) begin
      res_q <= eci_pkg::apply_sign(neg_q, acc_q[95:32], |acc_q[127:96]);
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- hdl/eci_div.sv -----
module eci_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic        busy_q, fin_q, done_q, neg_q;
  logic [5:0]  cnt_q;
  logic [63:0] rem_q, lo_q, q_q, ub_q, res_q;
  logic [63:0] ua, ub, r2;
  logic        ge;

  assign ua = eci_pkg::mag64(a_i);
  assign ub = eci_pkg::mag64(b_i);
  // remainder stays below the divisor, so the shifted value fits 64 bits
  assign r2 = {rem_q[62:0], lo_q[63]};
  assign ge = (r2 >= ub_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        fin_q <= 1'b0;
        cnt_q <= 6'd63;
        if (b_i == 64'd0 || {32'd0, ua[63:32]} >= ub) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= a_i[63] ^ b_i[63];
      ub_q  <= ub;
      rem_q <= {32'd0, ua[63:32]};
      lo_q  <= {ua[31:0], 32'd0};
      q_q   <= '0;
      if (b_i == 64'd0) begin
        // zero divisor: zero over zero is zero, otherwise saturate
        res_q <= (a_i == 64'd0) ? 64'd0 : (a_i[63] ? eci_pkg::Q_MIN : eci_pkg::Q_MAX);
      end else begin
        res_q <= eci_pkg::apply_sign(a_i[63] ^ b_i[63], 64'd0, 1'b1);
      end
    end else if (busy_q) begin
      lo_q  <= {lo_q[62:0], 1'b0};
      rem_q <= ge ? (r2 - ub_q) : r2;
      q_q   <= {q_q[62:0], ge};
    end else if (fin_q) begin
      res_q <= eci_pkg::apply_sign(neg_q, q_q, 1'b0);
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- hdl/eci_dp.sv -----
module eci_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  eci_pkg::cmd_t             cmd_i,
  output eci_pkg::sts_t             sts_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  input  logic signed [31:0]        x_value_i,
  input  logic signed [31:0]        f_value_i,
  input  logic                      last_point_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [eci_pkg::IDX_W-1:0] interval_index_o,
  output logic [eci_pkg::IDX_W-1:0] start_point_o,
  output logic signed [63:0]        coef_zero_o,
  output logic signed [63:0]        coef_one_o,
  output logic signed [63:0]        coef_two_o,
  output logic signed [63:0]        coef_three_o,
  output logic                      final_result_o,
  output logic [1:0]                status_o
);

  logic                      mode_q;
  logic [eci_pkg::CNT_W-1:0] count_q, k_q;
  logic                      last_q;
  logic [31:0]               xw_q [4];
  logic [31:0]               fw_q [4];
  logic [63:0]               rf_q [32];
  logic [63:0]               ra_q, rb_q;
  logic [63:0]               nc_q [4];
  logic [63:0]               fit_q [3][4];
  logic [2:0]                marks_q;
  logic                      out_valid_q;
  logic [eci_pkg::IDX_W-1:0] interval_q, start_q;
  logic [63:0]               coef_q [4];
  logic                      final_q;
  logic [1:0]                status_q;

  logic                      last_eff;
  logic [31:0]               x_in;
  logic                      win_err;
  logic [31:0]               tap;
  logic [63:0]               wb_data, wr_data;
  logic [eci_pkg::RA_W-1:0]  wr_addr;
  logic                      wr_en;
  logic [63:0]               mul_res, div_res, dif, s_add, s_sub;
  logic                      mul_done, div_done;
  logic [31:0]               k32;
  logic [1:0]                ncand, best;
  logic [63:0]               m0, m1, m2, mb;
  logic                      sel1, sel2, err;
  logic                      out_free;

  assign last_eff = last_point_i ||
                    (count_q == eci_pkg::CNT_W'(eci_pkg::MAX_POINTS - 1));
  // index mode: abscissa is the point number in Q16.16
  assign x_in = mode_q ? 32'({count_q, 16'd0}) : x_value_i;

  assign win_err = (xw_q[0] == xw_q[1]) || (xw_q[0] == xw_q[2]) ||
                   (xw_q[0] == xw_q[3]) || (xw_q[1] == xw_q[2]) ||
                   (xw_q[1] == xw_q[3]) || (xw_q[2] == xw_q[3]);

  assign tap = cmd_i.load_idx[2] ? fw_q[cmd_i.load_idx[1:0]] : xw_q[cmd_i.load_idx[1:0]];

  // saturating add and subtract
  assign dif   = ra_q - rb_q;
  assign s_sub = (ra_q[63] != rb_q[63] && dif[63] != ra_q[63]) ?
                 (ra_q[63] ? eci_pkg::Q_MIN : eci_pkg::Q_MAX) : dif;
  always_comb begin
    logic [63:0] s;
    s     = ra_q + rb_q;
    s_add = (ra_q[63] == rb_q[63] && s[63] != ra_q[63]) ?
            (ra_q[63] ? eci_pkg::Q_MIN : eci_pkg::Q_MAX) : s;
  end

  always_comb begin
    case (cmd_i.uop.op)
      eci_pkg::OP_XSUB: wb_data = dif;
      eci_pkg::OP_SSUB: wb_data = s_sub;
      eci_pkg::OP_SADD: wb_data = s_add;
      eci_pkg::OP_MUL:  wb_data = mul_res;
      eci_pkg::OP_DIV:  wb_data = div_res;
      default:          wb_data = dif;
    endcase
  end

  assign wr_en   = cmd_i.load_en || cmd_i.wb_en;
  assign wr_addr = cmd_i.load_en ? eci_pkg::RA_W'(cmd_i.load_idx) : cmd_i.uop.dst;
  assign wr_data = cmd_i.load_en ? {{16{tap[31]}}, tap, 16'd0} : wb_data;

  eci_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (ra_q),
    .b_i     (rb_q),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  eci_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .a_i     (ra_q),
    .b_i     (rb_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  // candidate choice for the interval being emitted
  assign k32 = 32'(k_q);
  always_comb begin
    case (cmd_i.emit_idx)
      2'd0:    ncand = (k32 >= 32'd5) ? 2'd3 : ((k32 >= 32'd4) ? 2'd2 : 2'd1);
      2'd1:    ncand = (k32 >= 32'd4) ? 2'd2 : 2'd1;
      default: ncand = 2'd1;
    endcase
    m0   = eci_pkg::mag64(fit_q[0][3]);
    m1   = eci_pkg::mag64(fit_q[1][3]);
    m2   = eci_pkg::mag64(fit_q[2][3]);
    sel1 = (ncand >= 2'd2) && (m1 < m0);
    mb   = sel1 ? m1 : m0;
    sel2 = (ncand == 2'd3) && (m2 < mb);
    err  = marks_q[0] || ((ncand >= 2'd2) && marks_q[1]) ||
           ((ncand == 2'd3) && marks_q[2]);
    if (err) begin
      best = 2'd0;
    end else if (sel2) begin
      best = 2'd2;
    end else if (sel1) begin
      best = 2'd1;
    end else begin
      best = 2'd0;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      count_q     <= '0;
      k_q         <= '0;
      last_q      <= 1'b0;
      marks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        k_q     <= count_q;
        last_q  <= last_eff;
        count_q <= last_eff ? '0 : count_q + eci_pkg::CNT_W'(1);
      end
      if (cmd_i.commit) begin
        marks_q <= {marks_q[1:0], win_err};
      end
      if (cmd_i.emit_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      for (int i = 0; i < 3; i++) begin
        xw_q[i] <= xw_q[i+1];
        fw_q[i] <= fw_q[i+1];
      end
      xw_q[3] <= x_in;
      fw_q[3] <= f_value_i;
    end
    if (wr_en) begin
      rf_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      ra_q <= rf_q[cmd_i.uop.sa];
      rb_q <= rf_q[cmd_i.uop.sb];
    end
    if (cmd_i.wb_en) begin
      if (cmd_i.uop.dst == eci_pkg::R_C0) nc_q[0] <= wb_data;
      if (cmd_i.uop.dst == eci_pkg::R_C1) nc_q[1] <= wb_data;
      if (cmd_i.uop.dst == eci_pkg::R_C2) nc_q[2] <= wb_data;
      if (cmd_i.uop.dst == eci_pkg::R_A3) nc_q[3] <= wb_data;
    end
    if (cmd_i.commit) begin
      fit_q[2] <= fit_q[1];
      fit_q[1] <= fit_q[0];
      for (int j = 0; j < 4; j++) begin
        fit_q[0][j] <= win_err ? 64'd0 : nc_q[j];
      end
    end
    if (cmd_i.emit_en) begin
      if (last_q && k32 < 32'd3) begin
        interval_q <= '0;
        start_q    <= '0;
        for (int j = 0; j < 4; j++) coef_q[j] <= '0;
        final_q    <= 1'b1;
        status_q   <= eci_pkg::ST_SHORT;
      end else begin
        interval_q <= eci_pkg::IDX_W'(k32 - 32'd3 + 32'(cmd_i.emit_idx));
        start_q    <= eci_pkg::IDX_W'(k32 - 32'd3 - 32'(best));
        for (int j = 0; j < 4; j++) coef_q[j] <= err ? 64'd0 : fit_q[best][j];
        final_q    <= (cmd_i.emit_idx == 2'd2);
        status_q   <= err ? eci_pkg::ST_DUP : eci_pkg::ST_OK;
      end
    end
  end

  assign sts_o.k_ge3       = (k32 >= 32'd3);
  assign sts_o.last        = last_q;
  assign sts_o.short_curve = last_q && (k32 < 32'd3);
  assign sts_o.win_err     = win_err;
  assign sts_o.mul_done    = mul_done;
  assign sts_o.div_done    = div_done;
  assign sts_o.out_free    = out_free;

  assign out_valid_o      = out_valid_q;
  assign interval_index_o = interval_q;
  assign start_point_o    = start_q;
  assign coef_zero_o      = coef_q[0];
  assign coef_one_o       = coef_q[1];
  assign coef_two_o       = coef_q[2];
  assign coef_three_o     = coef_q[3];
  assign final_result_o   = final_q;
  assign status_o         = status_q;

endmodule

// ----- hdl/eci_ctrl.sv -----
module eci_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  eci_pkg::sts_t sts_i,
  output eci_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_LOAD,
    S_READ,
    S_EXEC,
    S_WAIT,
    S_COMMIT,
    S_EMIT
  } state_e;

  state_e                   state_q;
  logic [eci_pkg::PC_W-1:0] pc_q;
  logic [2:0]               cnt_q;
  logic [1:0]               j_q;
  eci_pkg::uop_t            uop;
  logic                     long_op, unit_done, pc_end;
  logic [1:0]               j_end;

  assign uop       = eci_pkg::uprog(pc_q);
  assign long_op   = (uop.op == eci_pkg::OP_MUL) || (uop.op == eci_pkg::OP_DIV);
  assign unit_done = (uop.op == eci_pkg::OP_MUL) ? sts_i.mul_done : sts_i.div_done;
  assign pc_end    = (pc_q == eci_pkg::PC_W'(eci_pkg::NUM_UOPS - 1));
  assign j_end     = (sts_i.short_curve || !sts_i.last) ? 2'd0 : 2'd2;

  always_comb begin
    cmd_o          = '0;
    cmd_o.uop      = uop;
    cmd_o.load_idx = cnt_q;
    cmd_o.emit_idx = j_q;
    case (state_q)
      S_IDLE:   cmd_o.accept = in_valid_i;
      S_LOAD:   cmd_o.load_en = 1'b1;
      S_READ:   cmd_o.rd_en = 1'b1;
      S_EXEC: begin
        cmd_o.mul_start = (uop.op == eci_pkg::OP_MUL);
        cmd_o.div_start = (uop.op == eci_pkg::OP_DIV);
        cmd_o.wb_en     = !long_op;
      end
      S_WAIT:   cmd_o.wb_en = unit_done;
      S_COMMIT: cmd_o.commit = 1'b1;
      S_EMIT:   cmd_o.emit_en = sts_i.out_free;
      default:  cmd_o.accept = 1'b0;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      cnt_q   <= '0;
      j_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          j_q <= '0;
          if (sts_i.short_curve) begin
            state_q <= S_EMIT;
          end else if (!sts_i.k_ge3) begin
            state_q <= S_IDLE;
          end else if (sts_i.win_err) begin
            state_q <= S_COMMIT;
          end else begin
            cnt_q   <= '0;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd7) begin
            pc_q    <= '0;
            state_q <= S_READ;
          end
        end
        S_READ:   state_q <= S_EXEC;
        S_EXEC: begin
          if (long_op) begin
            state_q <= S_WAIT;
          end else if (pc_end) begin
            state_q <= S_COMMIT;
          end else begin
            pc_q    <= pc_q + eci_pkg::PC_W'(1);
            state_q <= S_READ;
          end
        end
        S_WAIT: begin
          if (unit_done) begin
            if (pc_end) begin
              state_q <= S_COMMIT;
            end else begin
              pc_q    <= pc_q + eci_pkg::PC_W'(1);
              state_q <= S_READ;
            end
          end
        end
        S_COMMIT: begin
          j_q     <= '0;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (sts_i.out_free) begin
            if (j_q == j_end) begin
              state_q <= S_IDLE;
            end else begin
              j_q <= j_q + 2'd1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_en |-> sts_i.out_free)
    else $error("result loaded while output register busy");
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.mul_start && cmd_o.div_start))
    else $error("multiplier and divider started together");
  a_wait_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT) |-> (uop.op == eci_pkg::OP_MUL || uop.op == eci_pkg::OP_DIV))
    else $error("waiting on a single-cycle op");
  a_start_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.mul_start || cmd_o.div_start) |=> (state_q == S_WAIT))
    else $error("unit started without waiting for it");
`endif

endmodule

// ----- hdl/eno_cubic_interpolator.sv -----
// Streaming third-order ENO interpolator. Points (x, f) in signed Q16.16 enter one
// item at a time; from the fourth point of a curve on, every point fits a cubic to the
// last four points and emits one interval with coefficients in saturating Q32.32, and
// the point marked last (or point MAX_POINTS-1) also emits the two closing intervals.
// A point that completes a fit keeps the input stalled while the fit runs: the fit is
// a 49-step program run on one scratch register file, dominated by three restoring
// divisions and 23 four-pass 32x32 multiplications. A window with a repeated abscissa
// skips the program. The first three points of a curve run no fit; one of them marked
// last emits a short-curve result. Results sit in an output register, so the last
// result may wait on out_stall_i without loss. cfg_we_i writes index_abscissa_mode;
// the user must write it only while the block is idle; the block does not enforce it.
module eno_cubic_interpolator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [31:0]        x_value_i,
  input  logic signed [31:0]        f_value_i,
  input  logic                      last_point_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [eci_pkg::IDX_W-1:0] interval_index_o,
  output logic [eci_pkg::IDX_W-1:0] start_point_o,
  output logic signed [63:0]        coef_zero_o,
  output logic signed [63:0]        coef_one_o,
  output logic signed [63:0]        coef_two_o,
  output logic signed [63:0]        coef_three_o,
  output logic                      final_result_o,
  output logic [1:0]                status_o
);

  // command and status between sequencer and datapath
  eci_pkg::cmd_t cmd;
  eci_pkg::sts_t sts;

  eci_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  eci_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .x_value_i        (x_value_i),
    .f_value_i        (f_value_i),
    .last_point_i     (last_point_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .interval_index_o (interval_index_o),
    .start_point_o    (start_point_o),
    .coef_zero_o      (coef_zero_o),
    .coef_one_o       (coef_one_o),
    .coef_two_o       (coef_two_o),
    .coef_three_o     (coef_three_o),
    .final_result_o   (final_result_o),
    .status_o         (status_o)
  );

endmodule
